// ===== hdl/assert_macros.svh =====
// assert_macros.svh
// Assertion shorthands for the scanner. The using module must have clk and
// rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MWVS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MWVS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define MWVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mwvs_pkg.sv =====
// ============================================================================
// mwvs_pkg
// Shared types, constants and the width-compare function of the scanner.
// ============================================================================
package mwvs_pkg;

    localparam int ADDRESS_BITS_DEF = 48;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int VALUE_W  = 64;
    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 49;
    localparam int MASK_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST      = 2'd3;

    // Width mask bits
    localparam logic [MASK_W-1:0] HIT_W8  = 4'h1;
    localparam logic [MASK_W-1:0] HIT_W16 = 4'h2;
    localparam logic [MASK_W-1:0] HIT_W32 = 4'h4;
    localparam logic [MASK_W-1:0] HIT_W64 = 4'h8;
    localparam logic [MASK_W-1:0] HIT_NONE = 4'h0;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_EQ8   = 3'd1,
        MODE_EQ16  = 3'd2,
        MODE_EQ32  = 3'd3,
        MODE_EQ64  = 3'd4,
        MODE_ALL   = 3'd5,
        MODE_MIN16 = 3'd6,
        MODE_MIN32 = 3'd7
    } mwvs_mode_t;

    // One in-range window position waiting for evaluation
    typedef struct packed {
        logic [VALUE_W-1:0] window;
        logic [ADDR_W-1:0]  offset;
    } mwvs_item_t;

    // Front to queue write side
    typedef struct packed {
        logic       valid;
        mwvs_item_t item;
    } mwvs_push_t;

    // Queue read side to back
    typedef struct packed {
        logic       valid;
        mwvs_item_t item;
    } mwvs_head_t;

    function automatic logic [MASK_W-1:0] width_hits(
        input logic [VALUE_W-1:0] window,
        input logic [VALUE_W-1:0] ref_value,
        input mwvs_mode_t         mode
    );
        logic [VALUE_W-1:0] diff;
        logic eq8;
        logic eq16;
        logic eq32;
        logic eq64;
        logic [MASK_W-1:0] hits;
        diff = window ^ ref_value;
        eq8  = (diff[7:0] == 8'd0);
        eq16 = (diff[15:0] == 16'd0);
        eq32 = (diff[31:0] == 32'd0);
        eq64 = (diff == 64'd0);
        case (mode)
            MODE_EQ8:  hits = eq8  ? HIT_W8  : HIT_NONE;
            MODE_EQ16: hits = eq16 ? HIT_W16 : HIT_NONE;
            MODE_EQ32: hits = eq32 ? HIT_W32 : HIT_NONE;
            MODE_EQ64: hits = eq64 ? HIT_W64 : HIT_NONE;
            MODE_ALL:
                hits = !eq8  ? HIT_NONE
                     : !eq16 ? HIT_W8
                     : !eq32 ? (HIT_W8 | HIT_W16)
                     : !eq64 ? (HIT_W8 | HIT_W16 | HIT_W32)
                     : (HIT_W8 | HIT_W16 | HIT_W32 | HIT_W64);
            MODE_MIN16:
                hits = !eq16 ? HIT_NONE
                     : !eq32 ? HIT_W16
                     : !eq64 ? (HIT_W16 | HIT_W32)
                     : (HIT_W16 | HIT_W32 | HIT_W64);
            MODE_MIN32:
                hits = !eq32 ? HIT_NONE
                     : !eq64 ? HIT_W32
                     : (HIT_W32 | HIT_W64);
            default:   hits = HIT_NONE;
        endcase
        return hits;
    endfunction

endpackage

// ===== hdl/mwvs_front.sv =====
// ============================================================================
// mwvs_front
// Byte window, saturating byte counter and offset range check.
// ============================================================================
module mwvs_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      data_byte,
    input  logic [mwvs_pkg::ADDR_W-1:0]     last_offset,
    output mwvs_pkg::mwvs_push_t            push_out,
    output logic [mwvs_pkg::COUNT_W-1:0]    count_out
);

    localparam logic [mwvs_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [mwvs_pkg::COUNT_W-1:0] LAG       = mwvs_pkg::COUNT_W'(7);

    logic [mwvs_pkg::VALUE_W-1:0] window_reg;
    logic [mwvs_pkg::VALUE_W-1:0] window_next;
    logic [mwvs_pkg::COUNT_W-1:0] count_reg;
    logic [mwvs_pkg::COUNT_W-1:0] count_next;
    logic [mwvs_pkg::COUNT_W-1:0] offset_full;
    logic                         in_range;

    // Offset of the window's oldest byte once this byte enters
    assign offset_full = count_reg - LAG;
    assign in_range    = (count_reg != COUNT_MAX) && (count_reg >= LAG)
                      && (offset_full <= {1'b0, last_offset});

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (accept)
        begin
            window_next = {data_byte, window_reg[mwvs_pkg::VALUE_W-1:8]};
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + mwvs_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    assign push_out.valid       = accept && in_range;
    assign push_out.item.window = window_next;
    assign push_out.item.offset = offset_full[mwvs_pkg::ADDR_W-1:0];
    assign count_out            = count_reg;

endmodule

// ===== hdl/mwvs_queue.sv =====
// ============================================================================
// mwvs_queue
// Short register queue between front and back.
// ============================================================================
module mwvs_queue
#(
    parameter int DEPTH = mwvs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwvs_pkg::mwvs_push_t       push_in,
    input  logic                       pop,
    output mwvs_pkg::mwvs_head_t       head,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    mwvs_pkg::mwvs_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push_in.valid && (count_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_in.item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign level      = count_reg;

endmodule

// ===== hdl/mwvs_back.sv =====
// ============================================================================
// mwvs_back
// Width compare, address add and result register.
// ============================================================================
module mwvs_back
#(
    parameter int ADDRESS_BITS = mwvs_pkg::ADDRESS_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mwvs_pkg::mwvs_head_t            head,
    input  logic [mwvs_pkg::VALUE_W-1:0]    reference_value,
    input  mwvs_pkg::mwvs_mode_t            match_mode,
    input  logic [mwvs_pkg::ADDR_W-1:0]     base_address,
    input  logic                            pop,
    output logic                            head_pop,
    output logic                            empty,
    output logic [mwvs_pkg::ADDR_W-1:0]     match_address,
    output logic [mwvs_pkg::MASK_W-1:0]     width_mask
);

    // Wrap at ADDRESS_BITS, then keep the low 48 bits
    localparam logic [mwvs_pkg::ADDR_W-1:0] KEEP_MASK =
        (ADDRESS_BITS >= mwvs_pkg::ADDR_W) ? {mwvs_pkg::ADDR_W{1'b1}}
        : ((mwvs_pkg::ADDR_W'(1) << ADDRESS_BITS) - mwvs_pkg::ADDR_W'(1));

    logic                          valid_reg;
    logic                          valid_next;
    logic [mwvs_pkg::ADDR_W-1:0]   address_reg;
    logic [mwvs_pkg::MASK_W-1:0]   mask_reg;
    logic [mwvs_pkg::MASK_W-1:0]   hits;
    logic [mwvs_pkg::ADDR_W-1:0]   sum;
    logic                          take_out;
    logic                          load;

    assign hits     = mwvs_pkg::width_hits(head.item.window, reference_value, match_mode);
    assign sum      = (base_address + head.item.offset) & KEEP_MASK;
    assign take_out = pop && valid_reg;
    assign load     = head.valid && (!valid_reg || take_out);

    always_comb
    begin
        valid_next = valid_reg;
        if (load && (hits != mwvs_pkg::HIT_NONE))
        begin
            valid_next = 1'b1;
        end
        else if (take_out)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && (hits != mwvs_pkg::HIT_NONE))
        begin
            address_reg <= sum;
            mask_reg    <= hits;
        end
    end

    assign head_pop      = load;
    assign empty         = !valid_reg;
    assign match_address = address_reg;
    assign width_mask    = mask_reg;

endmodule

// ===== hdl/multi_width_value_scanner_unit.sv =====
// ============================================================================
// multi_width_value_scanner_unit
// Scans a byte stream for a reference value at 8, 16, 32 and 64 bit widths.
// ============================================================================
// Usage:
//   Input channel: drive data_byte and raise push; a transaction completes on
//   a rising edge with push high and full low. Bytes arrive in address order.
//   Result channel: while empty is low, match_address and width_mask carry the
//   oldest result; raise pop to take it. Only offsets with a nonzero width
//   mask produce a result.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (0 reference, 1 mode, 2 base address, 3 last offset). Write only while
//   idle.
//   Throughput: one byte per cycle while full is low. The front accepts a byte every
//   cycle while the queue has room; the back retires one queue entry a cycle
//   while the result register is free or being popped.
//   Decision: a decision for offset k is made when byte k+7 arrives; its result
//   is written to the queue at the edge that accepts that byte, and loads the result
//   register once it is at the queue head and the result register is free or popped.
//   Reset: clears registers, window, byte counter, queue and result register.
//   A stalled receiver holds the result; the queue fills, then full rises.
// ============================================================================
`include "assert_macros.svh"

module multi_width_value_scanner_unit
#(
    parameter int ADDRESS_BITS = mwvs_pkg::ADDRESS_BITS_DEF,
    parameter int QUEUE_DEPTH  = mwvs_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [mwvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mwvs_pkg::VALUE_W-1:0]      cfg_data,
    // byte input
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    // results
    output logic                              empty,
    input  logic                              pop,
    output logic [mwvs_pkg::ADDR_W-1:0]       match_address,
    output logic [mwvs_pkg::MASK_W-1:0]       width_mask
);

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);

    logic [mwvs_pkg::VALUE_W-1:0] reference_reg;
    mwvs_pkg::mwvs_mode_t         mode_reg;
    logic [mwvs_pkg::ADDR_W-1:0]  base_reg;
    logic [mwvs_pkg::ADDR_W-1:0]  last_reg;

    mwvs_pkg::mwvs_push_t         front_push;
    mwvs_pkg::mwvs_head_t         queue_head;
    logic                         queue_full;
    logic [LEVEL_W-1:0]           queue_level;
    logic                         head_pop;
    logic                         in_accept;
    logic [mwvs_pkg::COUNT_W-1:0] bytes_seen;

    // ------------------------------------------------------------------------
    // Configuration registers; values are masked to each register's width
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_reg <= '0;
            mode_reg      <= mwvs_pkg::MODE_NONE;
            base_reg      <= '0;
            last_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mwvs_pkg::REG_REFERENCE: reference_reg <= cfg_data;
                mwvs_pkg::REG_MODE:      mode_reg <= mwvs_pkg::mwvs_mode_t'(cfg_data[2:0]);
                mwvs_pkg::REG_BASE:      base_reg <= cfg_data[mwvs_pkg::ADDR_W-1:0];
                mwvs_pkg::REG_LAST:      last_reg <= cfg_data[mwvs_pkg::ADDR_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Front: shift window, count bytes, classify offset in or out of range.
    // Hold input off while the queue is full.
    // ------------------------------------------------------------------------
    assign full      = queue_full;
    assign in_accept = push && !queue_full;

    mwvs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .last_offset(last_reg),
        .push_out   (front_push),
        .count_out  (bytes_seen)
    );

    // ------------------------------------------------------------------------
    // Queue: decouple front from back so each side can stall on its own
    // ------------------------------------------------------------------------
    mwvs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_in(front_push),
        .pop    (head_pop),
        .head   (queue_head),
        .full   (queue_full),
        .level  (queue_level)
    );

    // ------------------------------------------------------------------------
    // Back: compare widths, add base address, drop entries with no hit,
    // advance into the result register
    // ------------------------------------------------------------------------
    mwvs_back #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (queue_head),
        .reference_value(reference_reg),
        .match_mode     (mode_reg),
        .base_address   (base_reg),
        .pop            (pop),
        .head_pop       (head_pop),
        .empty          (empty),
        .match_address  (match_address),
        .width_mask     (width_mask)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `MWVS_ASSERT_ALWAYS(a_queue_bound, queue_level <= LEVEL_W'(QUEUE_DEPTH), "queue overfull")
    `MWVS_ASSERT_IMPLY(a_mask_nonzero, !empty, width_mask != mwvs_pkg::HIT_NONE, "zero mask")
    `MWVS_ASSERT_IMPLY(a_push_room, front_push.valid, !queue_full, "push into full queue")
    `MWVS_ASSERT_NEXT(a_count_sat, bytes_seen == '1, bytes_seen == '1, "counter left saturation")

endmodule
